>>> design/coca_pkg.sv
// ----------------------------------------------------------------------------
// coca_pkg
// Shared types and constants for the contig orientation cost accumulator:
// field widths, stream bit positions, action codes and the table entry layout.
// ----------------------------------------------------------------------------
package coca_pkg;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int ID_W   = 12;
  localparam int OFF_W  = 32;
  localparam int GRP_W  = 8;
  localparam int ORD_W  = 12;
  localparam int LEN_W  = 32;
  localparam int COST_W = 48;

  // Request stream layout (tdata, lowest bit first)
  localparam int IN_A_LSB    = 0;
  localparam int IN_B_LSB    = IN_A_LSB + ID_W;
  localparam int IN_OFFA_LSB = IN_B_LSB + ID_W;
  localparam int IN_OFFB_LSB = IN_OFFA_LSB + OFF_W;
  localparam int IN_GRP_LSB  = IN_OFFB_LSB + OFF_W;
  localparam int IN_ORD_LSB  = IN_GRP_LSB + GRP_W;
  localparam int IN_LEN_LSB  = IN_ORD_LSB + ORD_W;
  localparam int IN_USED_W   = IN_LEN_LSB + LEN_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Result stream layout (tdata, lowest bit first)
  localparam int OUT_USED_W = 3 + 2 * COST_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // Default sizing
  localparam int DEF_MAX_CONTIGS = 4096;
  localparam int DEF_MAX_GROUPS  = 256;
  localparam int DEF_SUM_BITS    = 48;

  // Request kinds
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_PAIR = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  // Per-contig bookkeeping stored beside the two sums
  typedef struct packed {
    logic             valid;
    logic [GRP_W-1:0] grp;
    logic [ORD_W-1:0] order;
    logic [LEN_W-1:0] len;
  } meta_t;

  // Term selection for the shared adder
  typedef struct packed {
    logic             use_rem;  // add clamped len - off instead of off
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } term_ctl_t;

endpackage

>>> design/contig_orientation_cost_accumulator.sv
// ----------------------------------------------------------------------------
// contig_orientation_cost_accumulator
// Per-contig table engine that accumulates forward and reverse orientation
// costs from read pairs, with load, pair and read requests.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | slave     | in_tvalid/in_tready | tuser: action, tdata: 7 fields
//  out_    | master    | out_tvalid/tready   | tdata: flags and two 48-bit costs
//
//  Requests are sequenced through the single table port and the shared adder;
//  a counted pair takes four adder passes and two table writes. in_tready is
//  low while a request is in flight.
//  After reset a clearing pass marks every table entry unassigned; no request
//  is accepted while it runs.
//  A finished result waits in the output register; the next request is taken
//  while it waits, and the engine stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module contig_orientation_cost_accumulator #(
  parameter int MAX_CONTIGS = coca_pkg::DEF_MAX_CONTIGS,
  parameter int MAX_GROUPS  = coca_pkg::DEF_MAX_GROUPS,
  parameter int SUM_BITS    = coca_pkg::DEF_SUM_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // action
  input  logic [coca_pkg::ACT_W-1:0]      in_tuser,
  // contig_a, contig_b, offset_a, offset_b, group_index, group_position,
  // contig_length
  input  logic [coca_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pair_counted, entry_valid, reversed, forward_cost, reverse_cost
  output logic [coca_pkg::OUT_DATA_W-1:0] out_tdata
);
  import coca_pkg::*;

  localparam int AW = $clog2(MAX_CONTIGS);
  localparam int MW = $bits(meta_t);
  localparam int EW = MW + 2 * SUM_BITS;
  localparam logic [31:0]   CID_LIMIT = 32'(MAX_CONTIGS);
  localparam logic [31:0]   GRP_LIMIT = 32'(MAX_GROUPS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CONTIGS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_GET_B, S_EVAL,
    S_FA, S_RA, S_WR_A, S_FB, S_RB, S_WR_B, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  action_t              act_r, act_nxt;
  logic [AW-1:0]        ida_r, ida_nxt, idb_r, idb_nxt;
  logic                 a_ok_r, a_ok_nxt, b_ok_r, b_ok_nxt, same_r, same_nxt;
  logic [OFF_W-1:0]     offa_r, offa_nxt, offb_r, offb_nxt;
  meta_t                ma_r, ma_nxt, mb_r, mb_nxt;
  logic [SUM_BITS-1:0]  fa_r, fa_nxt, ra_r, ra_nxt, fb_r, fb_nxt, rb_r, rb_nxt;
  logic                 gt_r, gt_nxt;
  logic                 pc_r, pc_nxt, ev_r, ev_nxt, rv_r, rv_nxt;
  logic [COST_W-1:0]    fc_r, fc_nxt, rc_r, rc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Request field decode
  logic [ID_W-1:0]      in_id_a, in_id_b;
  logic [OFF_W-1:0]     in_offa, in_offb;
  logic [GRP_W-1:0]     in_grp;
  logic [ORD_W-1:0]     in_ord;
  logic [LEN_W-1:0]     in_len;
  logic [AW+ID_W-1:0]   addr_a_ext, addr_b_ext;
  logic                 in_a_ok, in_b_ok, in_grp_ok;

  assign in_id_a = in_tdata[IN_A_LSB +: ID_W];
  assign in_id_b = in_tdata[IN_B_LSB +: ID_W];
  assign in_offa = in_tdata[IN_OFFA_LSB +: OFF_W];
  assign in_offb = in_tdata[IN_OFFB_LSB +: OFF_W];
  assign in_grp  = in_tdata[IN_GRP_LSB +: GRP_W];
  assign in_ord  = in_tdata[IN_ORD_LSB +: ORD_W];
  assign in_len  = in_tdata[IN_LEN_LSB +: LEN_W];

  assign addr_a_ext = {AW'(0), in_id_a};
  assign addr_b_ext = {AW'(0), in_id_b};
  assign in_a_ok    = 32'(in_id_a) < CID_LIMIT;
  assign in_b_ok    = 32'(in_id_b) < CID_LIMIT;
  assign in_grp_ok  = 32'(in_grp) < GRP_LIMIT;

  // Table and shared adder
  logic                 wr_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [EW-1:0]        wr_data, rd_data;
  meta_t                rd_meta;
  logic [SUM_BITS-1:0]  rd_fwd, rd_rev;
  term_ctl_t            add_ctl;
  logic [SUM_BITS-1:0]  add_acc, add_sum;
  meta_t                load_meta;

  coca_table #(.DEPTH(MAX_CONTIGS), .AW(AW), .DW(EW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  coca_satadd #(.SUM_BITS(SUM_BITS)) u_satadd (
    .ctl (add_ctl),
    .acc (add_acc),
    .sum (add_sum)
  );

  assign rd_meta = meta_t'(rd_data[EW-1 -: MW]);
  assign rd_fwd  = rd_data[2*SUM_BITS-1:SUM_BITS];
  assign rd_rev  = rd_data[SUM_BITS-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Widen or trim a sum to the 48-bit cost field
  function automatic logic [COST_W-1:0] to_cost(input logic [SUM_BITS-1:0] s);
    logic [COST_W+SUM_BITS-1:0] ext;
    begin
      ext = {COST_W'(0), s};
      return ext[COST_W-1:0];
    end
  endfunction

  // Table read address follows the sequencer
  always_comb begin
    unique case (state_r)
      S_RD_B:  rd_addr = idb_r;
      default: rd_addr = ida_r;
    endcase
  end

  // Shared adder operand selection
  always_comb begin
    add_ctl = '{use_rem: !gt_r, off: offa_r, len: ma_r.len};
    add_acc = fa_r;
    unique case (state_r)
      S_FA: begin
        add_ctl = '{use_rem: !gt_r, off: offa_r, len: ma_r.len};
        add_acc = fa_r;
      end
      S_RA: begin
        add_ctl = '{use_rem: gt_r, off: offa_r, len: ma_r.len};
        add_acc = ra_r;
      end
      S_FB: begin
        add_ctl = '{use_rem: gt_r, off: offb_r, len: mb_r.len};
        add_acc = fb_r;
      end
      S_RB: begin
        add_ctl = '{use_rem: !gt_r, off: offb_r, len: mb_r.len};
        add_acc = rb_r;
      end
      default: begin
        add_ctl = '{use_rem: !gt_r, off: offa_r, len: ma_r.len};
        add_acc = fa_r;
      end
    endcase
  end

  assign load_meta = '{valid: 1'b1, grp: in_grp, order: in_ord, len: in_len};

  // Sequencer next-state and table write port
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    act_nxt       = act_r;
    ida_nxt       = ida_r;
    idb_nxt       = idb_r;
    a_ok_nxt      = a_ok_r;
    b_ok_nxt      = b_ok_r;
    same_nxt      = same_r;
    offa_nxt      = offa_r;
    offb_nxt      = offb_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    fa_nxt        = fa_r;
    ra_nxt        = ra_r;
    fb_nxt        = fb_r;
    rb_nxt        = rb_r;
    gt_nxt        = gt_r;
    pc_nxt        = pc_r;
    ev_nxt        = ev_r;
    rv_nxt        = rv_r;
    fc_nxt        = fc_r;
    rc_nxt        = rc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_addr       = ida_r;
    wr_data       = {ma_r, fa_r, ra_r};

    unique case (state_r)
      // Mark every entry unassigned, one per cycle
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      // Take a request; loads with an in-range contig and group write straight into the table
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt  = action_t'(in_tuser);
          ida_nxt  = addr_a_ext[AW-1:0];
          idb_nxt  = addr_b_ext[AW-1:0];
          a_ok_nxt = in_a_ok;
          b_ok_nxt = in_b_ok;
          same_nxt = (in_id_a == in_id_b);
          offa_nxt = in_offa;
          offb_nxt = in_offb;
          pc_nxt   = 1'b0;
          ev_nxt   = 1'b0;
          rv_nxt   = 1'b0;
          fc_nxt   = '0;
          rc_nxt   = '0;
          unique case (in_tuser) inside
            ACT_LOAD: begin
              wr_en     = in_a_ok && in_grp_ok;
              wr_addr   = addr_a_ext[AW-1:0];
              wr_data   = {load_meta, {(2*SUM_BITS){1'b0}}};
              state_nxt = S_DONE;
            end
            ACT_PAIR, ACT_READ: state_nxt = S_RD_A;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      // Entry a arrives; a read finishes here
      S_RD_B: begin
        ma_nxt = rd_meta;
        fa_nxt = rd_fwd;
        ra_nxt = rd_rev;
        if (act_r == ACT_READ) begin
          if (a_ok_r && rd_meta.valid) begin
            ev_nxt = 1'b1;
            rv_nxt = rd_rev < rd_fwd;
            fc_nxt = to_cost(rd_fwd);
            rc_nxt = to_cost(rd_rev);
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_GET_B;
        end
      end
      S_GET_B: begin
        mb_nxt    = rd_meta;
        fb_nxt    = rd_fwd;
        rb_nxt    = rd_rev;
        state_nxt = S_EVAL;
      end
      // Skip unless both ids are in range and both ends are assigned to one group
      S_EVAL: begin
        gt_nxt = ma_r.order > mb_r.order;
        if (a_ok_r && b_ok_r && ma_r.valid && mb_r.valid && (ma_r.grp == mb_r.grp)) begin
          state_nxt = S_FA;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FA: begin
        fa_nxt    = add_sum;
        state_nxt = S_RA;
      end
      S_RA: begin
        ra_nxt    = add_sum;
        state_nxt = S_WR_A;
      end
      // Write entry a; a pair on one contig continues from the new sums
      S_WR_A: begin
        wr_en   = 1'b1;
        wr_addr = ida_r;
        wr_data = {ma_r, fa_r, ra_r};
        if (same_r) begin
          fb_nxt = fa_r;
          rb_nxt = ra_r;
        end
        state_nxt = S_FB;
      end
      S_FB: begin
        fb_nxt    = add_sum;
        state_nxt = S_RB;
      end
      S_RB: begin
        rb_nxt    = add_sum;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        wr_en     = 1'b1;
        wr_addr   = idb_r;
        wr_data   = {mb_r, fb_r, rb_r};
        pc_nxt    = 1'b1;
        state_nxt = S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {OUT_PAD_W'(0), rc_r, fc_r, rv_r, ev_r, pc_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    ida_r      <= ida_nxt;
    idb_r      <= idb_nxt;
    a_ok_r     <= a_ok_nxt;
    b_ok_r     <= b_ok_nxt;
    same_r     <= same_nxt;
    offa_r     <= offa_nxt;
    offb_r     <= offb_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    fa_r       <= fa_nxt;
    ra_r       <= ra_nxt;
    fb_r       <= fb_nxt;
    rb_r       <= rb_nxt;
    gt_r       <= gt_nxt;
    pc_r       <= pc_nxt;
    ev_r       <= ev_nxt;
    rv_r       <= rv_nxt;
    fc_r       <= fc_nxt;
    rc_r       <= rc_nxt;
    out_data_r <= out_data_nxt;
  end

  // One request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous request in flight");

  // A result never reports both a counted pair and a valid read
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("pair_counted and entry_valid both set");

  // Reversed only on a valid read
  a_reversed_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1])
    else $error("reversed set without a valid entry");

endmodule

>>> design/coca_table.sv
// ----------------------------------------------------------------------------
// coca_table
// Per-contig table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module coca_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 149
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/coca_satadd.sv
// ----------------------------------------------------------------------------
// coca_satadd
// Shared cost adder: adds either the offset or the clamped remaining length
// to a running sum and saturates at the all-ones sum value.
// ----------------------------------------------------------------------------
module coca_satadd #(
  parameter int SUM_BITS = 48
) (
  input  coca_pkg::term_ctl_t   ctl,
  input  logic [SUM_BITS-1:0]   acc,
  output logic [SUM_BITS-1:0]   sum
);
  import coca_pkg::*;

  logic [LEN_W-1:0]        term;
  logic [SUM_BITS:0]       total;

  // Pick the term; remaining length clamps at zero
  always_comb begin
    if (ctl.use_rem) begin
      term = (ctl.off >= ctl.len) ? '0 : (ctl.len - ctl.off);
    end else begin
      term = ctl.off;
    end
  end

  // Add with carry out, saturate on overflow
  assign total = {1'b0, acc} + (SUM_BITS + 1)'(term);
  assign sum   = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];

endmodule
